### hw/rtl/cbfe_pkg.sv
// ----------------------------------------------------------------------------
// cbfe_pkg
// Types and constants for the complex block-float encoder.
// ----------------------------------------------------------------------------
package cbfe_pkg;

  typedef enum logic [2:0] {
    CFG_MANT_WIDTH    = 3'd0,
    CFG_MANT_INT_BITS = 3'd1,
    CFG_MANT_SIGNED   = 3'd2,
    CFG_EXP_WIDTH     = 3'd3,
    CFG_EXP_SIGNED    = 3'd4,
    CFG_EXP_POSITIVE  = 3'd5
  } cfg_idx_t;

  // One decoded component: value = (neg ? -m : m) * 2^e.
  typedef struct packed {
    logic               neg;
    logic [23:0]        m;
    logic signed [11:0] e;
    logic [30:0]        mag;   // IEEE magnitude bits, for ordering
  } comp_t;

  // One component after the shift onto the mantissa grid.
  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [54:0] mag;
    logic        rem;
  } shr_t;

  localparam logic [7:0]         EXP_SPECIAL = 8'hFF;
  localparam logic [23:0]        INF_MANT    = 24'h800000;
  localparam logic signed [11:0] INF_EXP     = 12'sd877;
  localparam logic signed [11:0] INF_LOG     = 12'sd900;
  localparam logic signed [11:0] DENORM_EXP  = -12'sd149;
  localparam logic signed [11:0] EXP_BIAS    = 12'sd127;
  localparam logic signed [11:0] FRAC_BIAS   = 12'sd150;

endpackage

### hw/rtl/complex_block_float_encoder.sv
// ----------------------------------------------------------------------------
// complex_block_float_encoder
// Packs a complex IEEE single-precision sample into a shared-exponent word.
// ----------------------------------------------------------------------------
// A sample is taken in every cycle in which start is high; busy is always low.
// The packed word appears on out_packed_word, marked by a one-cycle
// out_valid strobe, in input order. The five register stages are
// decode and pick of the larger component, exponent search of that component,
// exponent clamp, shift onto the mantissa grid, and saturate and pack.
// Configuration writes are always ready and must be made with no samples
// in flight.
module complex_block_float_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_real_bits,
  input  logic [31:0] in_imag_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  output logic [63:0] out_packed_word
);
  import cbfe_pkg::*;

  // Configuration registers
  logic [4:0]        mant_width_r;
  logic signed [5:0] mant_int_bits_r;
  logic              mant_signed_r;
  logic [3:0]        exp_width_r;
  logic              exp_signed_r;
  logic              exp_positive_r;

  logic [4:0]         wm;
  logic signed [5:0]  ib;
  logic [3:0]         we;
  logic signed [12:0] emin, emax, ehalf, efull;
  logic [7:0]         emask;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mant_width_r    <= 5'd14;
      mant_int_bits_r <= 6'sd1;
      mant_signed_r   <= 1'b1;
      exp_width_r     <= 4'd4;
      exp_signed_r    <= 1'b0;
      exp_positive_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MANT_WIDTH:    mant_width_r    <= cfg_data[4:0];
        CFG_MANT_INT_BITS: mant_int_bits_r <= cfg_data[5:0];
        CFG_MANT_SIGNED:   mant_signed_r   <= cfg_data[0];
        CFG_EXP_WIDTH:     exp_width_r     <= cfg_data[3:0];
        CFG_EXP_SIGNED:    exp_signed_r    <= cfg_data[0];
        CFG_EXP_POSITIVE:  exp_positive_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wm = (mant_width_r == 5'd0) ? 5'd1 : mant_width_r;
    ib = (mant_int_bits_r == 6'sb10_0000) ? -6'sd31 : mant_int_bits_r;
    if (exp_width_r == 4'd0) begin
      we = 4'd1;
    end else if (exp_width_r > 4'd8) begin
      we = 4'd8;
    end else begin
      we = exp_width_r;
    end
    ehalf = 13'sd1 <<< (we - 4'd1);
    efull = 13'sd1 <<< we;
    emask = 8'(efull - 13'sd1);
    if (exp_signed_r) begin
      emin = -ehalf;
      emax = ehalf - 13'sd1;
    end else if (exp_positive_r) begin
      emin = 13'sd0;
      emax = efull - 13'sd1;
    end else begin
      emin = 13'sd1 - efull;
      emax = 13'sd0;
    end
  end

  function automatic comp_t decode_comp(logic [31:0] bits, logic sm);
    comp_t      c;
    logic [7:0] ef;
    logic [22:0] fr;
    logic       zeroed;
    ef = bits[30:23];
    fr = bits[22:0];
    c  = '0;
    // NaN counts as zero, and so does a negative value with unsigned mantissas.
    zeroed = (ef == EXP_SPECIAL && fr != 23'd0) || (!sm && bits[31]);
    if (!zeroed) begin
      c.mag = bits[30:0];
      if (ef == EXP_SPECIAL) begin
        c.m = INF_MANT;
        c.e = INF_EXP;
      end else if (ef == 8'd0) begin
        c.m = {1'b0, fr};
        c.e = DENORM_EXP;
      end else begin
        c.m = {1'b1, fr};
        c.e = $signed({4'd0, ef}) - FRAC_BIAS;
      end
      c.neg = bits[31] && (c.m != 24'd0);
    end
    return c;
  endfunction

  function automatic shr_t shift_comp(comp_t c, logic signed [12:0] base);
    shr_t               s;
    logic signed [12:0] sh;
    logic signed [12:0] k;
    logic [23:0]        lowmask;
    sh      = 13'(c.e) + base;
    k       = -sh;
    s       = '0;
    s.neg   = c.neg;
    lowmask = '0;
    if (sh >= 13'sd32) begin
      s.ovf = (c.m != 24'd0);
    end else if (sh >= 13'sd0) begin
      s.mag = 55'(c.m) << sh[4:0];
    end else if (k >= 13'sd25) begin
      s.rem = (c.m != 24'd0);
    end else begin
      lowmask = (24'd1 << k[4:0]) - 24'd1;
      s.mag   = 55'(c.m >> k[4:0]);
      s.rem   = (c.m & lowmask) != 24'd0;
    end
    return s;
  endfunction

  function automatic logic [31:0] sat_comp(shr_t s, logic [4:0] w, logic sm);
    logic [32:0] half, full, dmax, wmask;
    logic [55:0] nm, neg_nm;
    logic [31:0] r;
    half  = 33'd1 << (w - 5'd1);
    full  = 33'd1 << w;
    wmask = full - 33'd1;
    dmax  = sm ? (half - 33'd1) : wmask;
    nm     = 56'(s.mag) + 56'(s.rem);
    neg_nm = ~nm + 56'd1;
    if (s.neg) begin
      r = (s.ovf || nm > 56'(half)) ? half[31:0] : neg_nm[31:0];
    end else begin
      r = (s.ovf || s.mag > 55'(dmax)) ? dmax[31:0] : s.mag[31:0];
    end
    return r & wmask[31:0];
  endfunction

  // Stage 1: decode and pick the component of larger magnitude.
  logic        s1_valid_r, s1_zero_r, s1_big_neg_r;
  logic [30:0] s1_big_bits_r;
  comp_t       s1_rc_r, s1_ic_r;
  comp_t       rc_nxt, ic_nxt;
  logic        pick_real_nxt;

  always_comb begin
    rc_nxt = decode_comp(in_real_bits, mant_signed_r);
    ic_nxt = decode_comp(in_imag_bits, mant_signed_r);
    if (rc_nxt.mag != ic_nxt.mag) begin
      pick_real_nxt = rc_nxt.mag > ic_nxt.mag;
    end else begin
      pick_real_nxt = !rc_nxt.neg && ic_nxt.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
    s1_rc_r       <= rc_nxt;
    s1_ic_r       <= ic_nxt;
    s1_zero_r     <= (rc_nxt.m == 24'd0) && (ic_nxt.m == 24'd0);
    s1_big_neg_r  <= pick_real_nxt ? rc_nxt.neg : ic_nxt.neg;
    s1_big_bits_r <= pick_real_nxt ? rc_nxt.mag : ic_nxt.mag;
  end

  // Stage 2: floor(log2) of the larger component and whether it is a power of two.
  logic               s2_valid_r, s2_zero_r, s2_big_neg_r, s2_pow2_r;
  logic signed [11:0] s2_log_r;
  comp_t              s2_rc_r, s2_ic_r;
  logic signed [11:0] log_nxt;
  logic               pow2_nxt;
  logic [4:0]         msb_pos;

  always_comb begin
    msb_pos = '0;
    for (int i = 0; i < 23; i++) begin
      if (s1_big_bits_r[i]) begin
        msb_pos = 5'(i);
      end
    end
    if (s1_big_bits_r[30:23] == EXP_SPECIAL) begin
      log_nxt  = INF_LOG;
      pow2_nxt = 1'b1;
    end else if (s1_big_bits_r[30:23] == 8'd0) begin
      log_nxt  = DENORM_EXP + $signed({7'd0, msb_pos});
      pow2_nxt = $onehot(s1_big_bits_r[22:0]);
    end else begin
      log_nxt  = $signed({4'd0, s1_big_bits_r[30:23]}) - EXP_BIAS;
      pow2_nxt = (s1_big_bits_r[22:0] == 23'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_zero_r    <= s1_zero_r;
    s2_big_neg_r <= s1_big_neg_r;
    s2_pow2_r    <= pow2_nxt;
    s2_log_r     <= log_nxt;
    s2_rc_r      <= s1_rc_r;
    s2_ic_r      <= s1_ic_r;
  end

  // Stage 3: shared exponent, clamped to the legal range.
  logic               s3_valid_r, s3_zero_r;
  logic signed [9:0]  s3_ex_r;
  comp_t              s3_rc_r, s3_ic_r;
  logic signed [12:0] target, il, ib13;
  logic signed [9:0]  ex_nxt;

  always_comb begin
    ib13 = 13'(ib);
    il   = mant_signed_r ? (ib13 - 13'sd1) : ib13;
    // A negative leader is scaled so its magnitude lands in the upper half-open band.
    if (mant_signed_r && s2_big_neg_r) begin
      target = 13'(s2_log_r) + $signed({12'd0, !s2_pow2_r}) - ib13 + 13'sd1;
    end else begin
      target = 13'(s2_log_r) + 13'sd1 - il;
    end
    if (target < emin) begin
      ex_nxt = 10'(emin);
    end else if (target > emax) begin
      ex_nxt = 10'(emax);
    end else begin
      ex_nxt = 10'(target);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_zero_r <= s2_zero_r;
    s3_ex_r   <= ex_nxt;
    s3_rc_r   <= s2_rc_r;
    s3_ic_r   <= s2_ic_r;
  end

  // Stage 4: shift both components onto the mantissa grid.
  logic               s4_valid_r, s4_zero_r;
  logic signed [9:0]  s4_ex_r;
  shr_t               s4_rs_r, s4_is_r;
  logic signed [12:0] base_nxt;

  assign base_nxt = $signed({8'd0, wm}) - ib13 - 13'(s3_ex_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
    s4_zero_r <= s3_zero_r;
    s4_ex_r   <= s3_ex_r;
    s4_rs_r   <= shift_comp(s3_rc_r, base_nxt);
    s4_is_r   <= shift_comp(s3_ic_r, base_nxt);
  end

  // Stage 5: saturate, floor and pack.
  logic              out_valid_r;
  logic [63:0]       out_word_r, word_nxt;
  logic [31:0]       mr, mi;
  logic signed [9:0] ex_store;
  logic [7:0]        ef, zcode;

  always_comb begin
    mr       = sat_comp(s4_rs_r, wm, mant_signed_r);
    mi       = sat_comp(s4_is_r, wm, mant_signed_r);
    ex_store = (!exp_signed_r && !exp_positive_r) ? -s4_ex_r : s4_ex_r;
    ef       = ex_store[7:0] & emask;
    if (exp_signed_r) begin
      zcode = 8'd1 << (we - 4'd1);
    end else if (exp_positive_r) begin
      zcode = 8'd0;
    end else begin
      zcode = emask;
    end
    if (s4_zero_r) begin
      word_nxt = 64'(zcode);
    end else begin
      word_nxt = 64'(ef) | (64'(mi) << we) | (64'(mr) << (6'(we) + 6'(wm)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s4_valid_r;
    end
    out_word_r <= word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_packed_word = out_word_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 5))
    else $error("result strobe without a transfer five cycles earlier");

  a_zero_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    s4_zero_r |-> !s4_rs_r.ovf && !s4_is_r.ovf)
    else $error("zero sample flagged as overflow");

  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_valid_r && s4_zero_r) |=> out_packed_word[63:8] == 56'd0)
    else $error("zero sample word carries mantissa bits");

endmodule

### dv/tb_complex_block_float_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_block_float_encoder
// Self-checking bench for the complex block-float encoder: directed samples
// and random samples over a series of register settings, each output word
// compared against an internal block-float predictor.
// ----------------------------------------------------------------------------
module tb_complex_block_float_encoder;
  import cbfe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PIPE_DRAIN  = 10;
  localparam int N_PHASES    = 11;
  localparam int PHASE_ITEMS = 100;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_real_bits;
  logic [31:0] in_imag_bits;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        out_valid;
  logic [63:0] out_packed_word;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    bit          known;
    logic [63:0] word;
  } sample_row_t;

  // Encoder settings as held by the predictor (raw register contents).
  logic [4:0] mant_width_q;
  logic [5:0] mant_int_bits_q;
  logic       mant_signed_q;
  logic [3:0] exp_width_q;
  logic       exp_signed_q;
  logic       exp_positive_q;

  logic [63:0] expected_words[$];
  int          error_count;
  int          cycle_count;
  int          samples_sent;
  int          words_checked;
  bit          idle_enable;

  complex_block_float_encoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_real_bits   (in_real_bits),
    .in_imag_bits   (in_imag_bits),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_packed_word(out_packed_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic real pow2(int e);
    real r;
    r = 1.0;
    while (e > 0) begin
      r = r * 2.0;
      e--;
    end
    while (e < 0) begin
      r = r * 0.5;
      e++;
    end
    return r;
  endfunction

  // Infinity is treated as 2^900 and NaN as zero.
  function automatic real single_value(logic [31:0] bits);
    real mag;
    if (bits[30:23] == EXP_SPECIAL) begin
      if (bits[22:0] != 0) return 0.0;
      mag = pow2(900);
    end else if (bits[30:23] == 0) begin
      mag = real'(bits[22:0]) * pow2(-149);
    end else begin
      mag = real'({1'b1, bits[22:0]}) * pow2(int'(bits[30:23]) - 150);
    end
    return bits[31] ? -mag : mag;
  endfunction

  function automatic logic [63:0] mantissa_floor(real x, int w, int ib, bit sgn);
    real    s;
    longint dmax;
    longint dmin;
    longint r;
    logic [63:0] mask;
    s = x * pow2(w - ib);
    dmax = sgn ? ((64'sd1 <<< (w - 1)) - 1) : ((64'sd1 <<< w) - 1);
    dmin = sgn ? -(64'sd1 <<< (w - 1)) : 0;
    if (s < real'(dmin)) r = dmin;
    else if (s >= real'(dmax) + 1.0) r = dmax;
    else begin
      r = longint'(s);
      if (real'(r) > s) r--;
    end
    mask = (64'd1 << w) - 1;
    return 64'(r) & mask;
  endfunction

  function automatic logic [63:0] block_float_word(logic [31:0] re_bits,
                                                   logic [31:0] im_bits);
    int  wm, ib, we, emin, emax, ex, il;
    bit  sm, se, ep;
    real re, im, ar, ai, big, lo, hi;
    logic [63:0] emask, word;
    wm = (mant_width_q == 0) ? 1 : int'(mant_width_q);
    ib = int'($signed(mant_int_bits_q));
    if (ib < -31) ib = -31;
    we = (exp_width_q == 0) ? 1 : ((exp_width_q > 8) ? 8 : int'(exp_width_q));
    sm = mant_signed_q;
    se = exp_signed_q;
    ep = exp_positive_q;
    emask = (64'd1 << we) - 1;
    emin = se ? -(1 << (we - 1)) : (ep ? 0 : -(1 << we) + 1);
    emax = se ? (1 << (we - 1)) - 1 : (ep ? (1 << we) - 1 : 0);
    ex = 0;
    re = single_value(re_bits);
    im = single_value(im_bits);
    if (!sm && re < 0.0) re = 0.0;
    if (!sm && im < 0.0) im = 0.0;
    if (re == 0.0 && im == 0.0)
      return 64'(se ? emin : -emin) & emask;
    ar = re < 0.0 ? -re : re;
    ai = im < 0.0 ? -im : im;
    if (ar > ai) big = re;
    else if (ar < ai) big = im;
    else big = (re > im) ? re : im;
    if (big > 0.0) begin
      il = sm ? ib - 1 : ib;
      lo = pow2(il - 1);
      hi = lo * 2.0;
      while (big < lo && ex > emin) begin
        big = big * 2.0; re = re * 2.0; im = im * 2.0; ex--;
      end
      while (big >= hi && ex < emax) begin
        big = big * 0.5; re = re * 0.5; im = im * 0.5; ex++;
      end
    end else begin
      lo = -pow2(ib - 1);
      hi = lo * 0.5;
      while (big < lo && ex < emax) begin
        big = big * 0.5; re = re * 0.5; im = im * 0.5; ex++;
      end
      while (big >= hi && ex > emin) begin
        big = big * 2.0; re = re * 2.0; im = im * 2.0; ex--;
      end
    end
    if (!se && !ep) ex = -ex;
    word = 64'(ex) & emask;
    word |= mantissa_floor(im, wm, ib, sm) << we;
    word |= mantissa_floor(re, wm, ib, sm) << (we + wm);
    return word;
  endfunction

  function automatic logic [31:0] random_single();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1:    v = $urandom;
      2, 3, 4: v = {1'($urandom), 8'($urandom_range(110, 145)), 23'($urandom)};
      5:       v = {1'($urandom), 8'($urandom_range(0, 3)), 23'($urandom)};
      6:       v = {1'($urandom), 8'($urandom_range(200, 254)), 23'($urandom)};
      7:       v = {1'($urandom), EXP_SPECIAL, ($urandom_range(0, 1) ? 23'd0 : 23'($urandom))};
      8:       v = {1'($urandom), 31'd0};
      default: v = {1'($urandom), 8'($urandom_range(120, 130)), 23'd0};
    endcase
    return v;
  endfunction

  // Idle cycles drop the strobe of the channel in use while idle_enable is set, each one added at random.
  task automatic idle_gap(bit cfg_side);
    while (idle_enable && $urandom_range(0, 99) < 18) begin
      if (cfg_side) cfg_valid <= 1'b0;
      else start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic send_sample(logic [31:0] re, logic [31:0] im);
    idle_gap(1'b0);
    start        <= 1'b1;
    in_real_bits <= re;
    in_imag_bits <= im;
    do @(posedge clk); while (busy);
    expected_words.push_back(block_float_word(re, im));
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [7:0] data);
    idle_gap(1'b1);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MANT_WIDTH:    mant_width_q    = data[4:0];
      CFG_MANT_INT_BITS: mant_int_bits_q = data[5:0];
      CFG_MANT_SIGNED:   mant_signed_q   = data[0];
      CFG_EXP_WIDTH:     exp_width_q     = data[3:0];
      CFG_EXP_SIGNED:    exp_signed_q    = data[0];
      CFG_EXP_POSITIVE:  exp_positive_q  = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  // Output words are sampled at the rising edge, oldest expectation first.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_packed_word);
        error_count++;
      end else begin
        if (out_packed_word !== expected_words[0]) begin
          $display("%0t: packed_word mismatch, expected %h, actual %h",
                   $time, expected_words[0], out_packed_word);
          error_count++;
        end
        void'(expected_words.pop_front());
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    sample_row_t rows[$];
    logic [7:0]  settings[N_PHASES][6];
    logic [31:0] re;
    logic [31:0] im;
    logic [63:0] got;

    error_count = 0;
    cycle_count = 0;
    samples_sent = 0;
    words_checked = 0;
    idle_enable = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_real_bits = '0;
    in_imag_bits = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MANT_WIDTH;
    cfg_data = '0;
    mant_width_q = 5'd14;
    mant_int_bits_q = 6'd1;
    mant_signed_q = 1'b1;
    exp_width_q = 4'd4;
    exp_signed_q = 1'b0;
    exp_positive_q = 1'b0;

    // Under reset settings a zero sample is the negated minimum exponent alone.
    rows = '{
      '{32'h0000_0000, 32'h0000_0000, 1, 64'hF},
      '{32'h8000_0000, 32'h8000_0000, 1, 64'hF},
      '{32'h7FC0_0000, 32'hFFC0_0001, 1, 64'hF},
      '{32'h0000_0000, 32'h7FC0_0000, 1, 64'hF},
      '{32'h3F80_0000, 32'h0000_0000, 0, 64'h0},
      '{32'h0000_0000, 32'hBF80_0000, 0, 64'h0},
      '{32'h7F80_0000, 32'h3F80_0000, 0, 64'h0},
      '{32'hFF80_0000, 32'h7F80_0000, 0, 64'h0},
      '{32'h7F7F_FFFF, 32'hFF7F_FFFF, 0, 64'h0},
      '{32'h0000_0001, 32'h8000_0001, 0, 64'h0},
      '{32'h007F_FFFF, 32'h0080_0000, 0, 64'h0},
      '{32'h3F00_0000, 32'hBF00_0000, 0, 64'h0},
      '{32'hBF00_0000, 32'h3F00_0000, 0, 64'h0},
      '{32'h3E80_0000, 32'h3E7F_FFFF, 0, 64'h0},
      '{32'hFFFF_FFFF, 32'hAAAA_AAAA, 0, 64'h0},
      '{32'h5555_5555, 32'h0F0F_0F0F, 0, 64'h0},
      '{32'h4120_0000, 32'hC120_0000, 0, 64'h0}
    };

    // Per phase: mant_width, mant_int_bits, mant_signed, exp_width,
    // exp_signed, exp_positive. Upper data bits are don't-care and random.
    settings[0]  = '{8'd14, 8'd1, 8'd1, 8'd4, 8'd0, 8'd0};
    settings[1]  = '{8'd31, 8'd31, 8'd0, 8'd8, 8'd0, 8'd1};
    settings[2]  = '{8'd0, 8'h20, 8'd1, 8'd0, 8'd1, 8'd0};
    settings[3]  = '{8'd31, 8'h21, 8'd1, 8'd15, 8'd1, 8'd1};
    settings[4]  = '{8'd1, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0};
    settings[5]  = '{8'd16, 8'd16, 8'd1, 8'd8, 8'd0, 8'd0};
    for (int p = 6; p < N_PHASES; p++)
      for (int k = 0; k < 6; k++) settings[p][k] = $urandom;
    for (int p = 0; p < N_PHASES; p++)
      for (int k = 0; k < 6; k++)
        settings[p][k] = settings[p][k] | (8'($urandom) & (k == 0 ? 8'hE0 :
                         k == 1 ? 8'hC0 : k == 3 ? 8'hF0 : 8'hFE));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      send_sample(rows[i].re, rows[i].im);
      if (rows[i].known && expected_words[$] !== rows[i].word) begin
        $display("%0t: predictor disagrees on row %0d, expected %h, actual %h",
                 $time, i, rows[i].word, expected_words[$]);
        error_count++;
      end
    end
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      for (int k = 0; k < 6; k++) write_register(cfg_idx_t'(k), settings[p][k]);
      cfg_valid <= 1'b0;
      idle_enable = (p != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        re = random_single();
        case ($urandom_range(0, 7))
          0:       im = re;
          1:       im = re ^ 32'h8000_0000;
          default: im = random_single();
        endcase
        send_sample(re, im);
      end
      wait_drained();
    end

    $display("Sent %0d samples over %0d register settings, checked %0d words.",
             samples_sent, N_PHASES + 1, words_checked);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
hw/rtl/cbfe_pkg.sv
hw/rtl/complex_block_float_encoder.sv
dv/tb_complex_block_float_encoder.sv
